>>> hdl/smpq_pkg.sv
// Shared types and constants for the sorted minimum priority queue.
// Used by smpq_cell and sorted_min_priority_queue; depends on nothing else.
package smpq_pkg;

  localparam int unsigned KeyW       = 32;
  localparam int unsigned CountW     = 5;
  localparam int unsigned QueueDepth = 16;

  localparam logic OpInsert = 1'b0;
  localparam logic OpRemove = 1'b1;

  typedef enum logic [1:0] {
    StatusOk        = 2'd0,
    StatusUnderflow = 2'd1,
    StatusOverflow  = 2'd2
  } status_e;

  typedef struct packed {
    logic                   operation;
    logic signed [KeyW-1:0] key;
  } req_t;

  typedef struct packed {
    logic signed [KeyW-1:0] removed_key;
    logic signed [KeyW-1:0] min_key;
    logic [CountW-1:0]      count;
    logic                   empty_res;
    status_e                status;
  } rsp_t;

  // Control broadcast from the top level to every cell.
  typedef struct packed {
    logic en;
    logic remove;
  } cell_ctrl_t;

endpackage

>>> hdl/smpq_cell.sv
// One slot of the sorted chain: holds a key and shifts it towards its neighbours.
// Depends on smpq_pkg.
module smpq_cell (
  input  logic                             clk_i,
  input  smpq_pkg::cell_ctrl_t             ctrl_i,
  input  logic                             occupied_i,
  input  logic signed [smpq_pkg::KeyW-1:0] new_key_i,
  input  logic signed [smpq_pkg::KeyW-1:0] left_key_i,
  input  logic signed [smpq_pkg::KeyW-1:0] right_key_i,
  input  logic                             left_less_i,
  output logic                             less_o,
  output logic signed [smpq_pkg::KeyW-1:0] key_o,
  output logic signed [smpq_pkg::KeyW-1:0] key_next_o
);
  import smpq_pkg::*;

  logic signed [KeyW-1:0] key_q, key_d;

  // Set when this slot holds a key that the new key must stay behind.
  assign less_o = occupied_i && (key_q < new_key_i);

  always_comb begin
    key_d = key_q;
    if (ctrl_i.en) begin
      if (ctrl_i.remove) begin
        key_d = right_key_i;
      end else if (!less_o) begin
        // The first slot not below the new key takes it; those after it shift up.
        key_d = left_less_i ? new_key_i : left_key_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
  end

  assign key_o      = key_q;
  assign key_next_o = key_d;

endmodule

>>> hdl/sorted_min_priority_queue.sv
// Top level of the sorted minimum priority queue: a chain of smpq_cell slots,
// the fill count and the result register. Depends on smpq_pkg and smpq_cell.
//
// Keys are held in ascending order in a row of Capacity cells, the smallest in
// the first cell. All cells compare the new key at once and each either keeps
// its key, takes the new key or takes a neighbour's key at the next clock edge,
// so a request may be accepted in every cycle while the result register is
// free or being read. Each request gives exactly one result. The slot contents
// are not cleared at reset; only slots below the count are ever read.
module sorted_min_priority_queue #(
  parameter int unsigned Capacity = smpq_pkg::QueueDepth
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  smpq_pkg::req_t in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output smpq_pkg::rsp_t out_data_o
);
  import smpq_pkg::*;

  localparam int unsigned CntW = $clog2(Capacity + 1);

  logic [CntW-1:0]        count_q, count_d;
  logic                   out_valid_q;
  rsp_t                   out_q;
  logic                   accept;
  logic                   is_remove, is_full, is_empty;
  status_e                status;
  cell_ctrl_t             ctrl;
  logic [Capacity-1:0]    less;
  logic signed [KeyW-1:0] keys [Capacity];
  logic signed [KeyW-1:0] keys_next [Capacity];

  assign in_stall_o = out_valid_q && out_stall_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign is_remove  = (in_data_i.operation == OpRemove);
  assign is_full    = (count_q == CntW'(Capacity));
  assign is_empty   = (count_q == '0);

  always_comb begin
    status  = StatusOk;
    count_d = count_q;
    if (is_remove) begin
      if (is_empty) status = StatusUnderflow;
      else count_d = count_q - 1'b1;
    end else begin
      if (is_full) status = StatusOverflow;
      else count_d = count_q + 1'b1;
    end
  end

  assign ctrl.en     = accept && (status == StatusOk);
  assign ctrl.remove = is_remove;

  for (genvar i = 0; i < Capacity; i++) begin : g_cell
    logic signed [KeyW-1:0] left_key, right_key;
    logic                   left_less;

    if (i == 0) begin : g_first
      assign left_key  = in_data_i.key;
      assign left_less = 1'b1;
    end else begin : g_inner
      assign left_key  = keys[i-1];
      assign left_less = less[i-1];
    end

    if (i == Capacity - 1) begin : g_last
      assign right_key = keys[i];
    end else begin : g_body
      assign right_key = keys[i+1];
    end

    smpq_cell u_cell (
      .clk_i       (clk_i),
      .ctrl_i      (ctrl),
      .occupied_i  (count_q > CntW'(i)),
      .new_key_i   (in_data_i.key),
      .left_key_i  (left_key),
      .right_key_i (right_key),
      .left_less_i (left_less),
      .less_o      (less[i]),
      .key_o       (keys[i]),
      .key_next_o  (keys_next[i])
    );
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (accept) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_q.removed_key <= (ctrl.en && is_remove) ? keys[0] : '0;
      out_q.min_key     <= (count_d != '0) ? keys_next[0] : '0;
      out_q.count       <= CountW'(count_d);
      out_q.empty_res   <= (count_d == '0);
      out_q.status      <= status;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Capacity))
    else $error("fill count above capacity");

  a_insert_grows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && !is_remove && !is_full |=> count_q == $past(count_q) + 1'b1)
    else $error("accepted insert did not grow the queue");

  a_underflow_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_q.status == StatusUnderflow) |->
      out_q.empty_res && (out_q.removed_key == '0))
    else $error("underflow result reports a non-empty queue");

  a_less_prefix: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (less[Capacity-1:1] & ~less[Capacity-2:0]) == '0)
    else $error("slots below the new key are not a prefix of the chain");
`endif

endmodule
